// ===== rtl/core/cti_pkg.sv =====
`default_nettype none

package cti_pkg;

    // default sizing
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] CFG_START_POS  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_INV_STEP   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_NUM_POINTS = 2'd2;

    // register reset values
    localparam logic [31:0] START_POS_RST  = 32'd0;
    localparam logic [31:0] INV_STEP_RST   = 32'd65536;
    localparam logic [10:0] NUM_POINTS_RST = 11'd1024;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // multiplier slicing
    localparam int SLICE_W = 32;

endpackage

`default_nettype wire

// ===== rtl/core/cubic_table_interpolator.sv =====
`default_nettype none

// cubic table interpolator, catmull-rom over a banked sample table
// command channel: a beat is taken at a rising edge with start high and busy low;
//   busy is tied low, so one beat may enter every cycle
// opcode load writes sample_value to table entry sample_index, no result beat
// opcode query normalizes position, picks a four-sample window and evaluates the cubic
// result channel: o_valid marks o_interp_value and o_saturated for exactly one cycle;
//   the receiver cannot stall, every result is taken in the cycle it shows
// pipeline: query results come out one per cycle sustained, through the seventeen
//   register stages: normalize multiply, window select, banked table read and three
//   chained cubic multiplies of two stages each
// table: four banks split by the two low address bits, one write and one read each,
//   so the four window samples come out in one registered read
// loads write the table at the same stage where queries read it, so accepted order holds
// reset: synchronous active low, clears valid bits and the config registers;
//   the table is not cleared, entries must be loaded before a query reads them
// config: plain write port; user writes only while no beat is in flight, unenforced
module cubic_table_interpolator #(
    parameter int TABLE_DEPTH = cti_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = cti_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_opcode,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] i_sample_index,
    input  wire logic signed [31:0]            i_sample_value,
    input  wire logic signed [31:0]            i_position,
    // result channel
    output logic                               o_valid,
    output logic signed [31:0]                 o_interp_value,
    output logic                               o_saturated,
    // config port
    input  wire logic                          i_cfg_we,
    input  wire logic [cti_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [cti_pkg::CFG_DW-1:0]    i_cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int BD  = (TABLE_DEPTH + 3) / 4;
    localparam int RW  = (BD > 1) ? $clog2(BD) : 1;
    // x spans the 32-bit u minus (base+1) scaled by 2^F
    localparam int XW  = ((AW + F + 2 > 32) ? AW + F + 2 : 32) + 1;
    localparam int MW1 = 33 + 34;
    localparam int QW  = MW1 - F;
    localparam int CW  = 36;
    localparam int M1W = XW + CW;
    localparam int S2W = M1W - F + 1;
    localparam int M2W = XW + S2W;
    localparam int S1W = M2W - F + 1;
    localparam int M3W = XW + S1W;
    localparam int TW  = M3W - F + 1;

    logic accept;

    // config registers
    logic signed [31:0] r_start_pos;
    logic [31:0]        r_inv_step;
    logic [10:0]        r_num_points;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos  <= cti_pkg::START_POS_RST;
            r_inv_step   <= cti_pkg::INV_STEP_RST;
            r_num_points <= cti_pkg::NUM_POINTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cti_pkg::CFG_START_POS:  r_start_pos  <= i_cfg_data[31:0];
                cti_pkg::CFG_INV_STEP:   r_inv_step   <= i_cfg_data[31:0];
                cti_pkg::CFG_NUM_POINTS: r_num_points <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // valid bits, one per stage
    logic [16:1] r_v;
    logic [5:1]  r_op;
    logic        n_f_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[15:6], n_f_v, r_v[4:1], accept};
        end
    end

    assign n_f_v = r_v[5] && (r_op[5] == cti_pkg::OP_QUERY);

    // load fields ride along to the table stage
    logic [AW-1:0] r_sidx [1:5];
    logic [31:0]   r_sval [1:5];

    always_ff @(posedge i_clk) begin
        r_op[1]   <= i_opcode;
        r_sidx[1] <= i_sample_index;
        r_sval[1] <= i_sample_value;
        for (int k = 2; k <= 5; k++) begin
            r_op[k]   <= r_op[k-1];
            r_sidx[k] <= r_sidx[k-1];
            r_sval[k] <= r_sval[k-1];
        end
    end

    // stage 1: position offset
    logic signed [32:0] r_d;
    logic signed [33:0] mag;
    logic signed [MW1-1:0] w_prod;
    logic [3:2] r_neg;

    always_ff @(posedge i_clk) begin
        r_d <= 33'(i_position) - 33'(r_start_pos);
    end

    assign mag = r_d[32] ? -34'(r_d) : 34'(r_d);

    cti_mul #(.AW(33), .BW(34)) u_mul_norm (
        .i_clk (i_clk),
        .i_a   ($signed({1'b0, r_inv_step})),
        .i_b   (mag),
        .o_p   (w_prod)
    );

    always_ff @(posedge i_clk) begin
        r_neg[2] <= r_d[32];
        r_neg[3] <= r_neg[2];
    end

    // stage 3: truncate and clip u
    logic [QW-1:0]      q;
    logic signed [31:0] n_u;
    logic               n_uclip;
    logic signed [31:0] r_u4;
    logic               r_clip4;

    always_comb begin
        q       = w_prod[MW1-1:F];
        n_uclip = 1'b0;
        if (r_neg[3]) begin
            // negative side reaches one step further
            if ((|q[QW-1:32]) || (q[31] && (|q[30:0]))) begin
                n_uclip = 1'b1;
                n_u     = 32'sh80000000;
            end else begin
                n_u = -$signed(q[31:0]);
            end
        end else begin
            if (|q[QW-1:31]) begin
                n_uclip = 1'b1;
                n_u     = 32'sh7fffffff;
            end else begin
                n_u = $signed(q[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u4    <= n_u;
        r_clip4 <= n_uclip;
    end

    // stage 4: window base
    logic [31:0]        num32;
    logic [31:0]        idx;
    logic [AW-1:0]      n_base;
    logic [AW-1:0]      r_base5;
    logic signed [31:0] r_u5;
    logic               r_clip5;

    always_comb begin
        num32 = 32'(r_num_points);
        if (num32 < 32'd4) begin
            num32 = 32'd4;
        end else if (num32 > 32'(TABLE_DEPTH)) begin
            num32 = 32'(TABLE_DEPTH);
        end
        idx = 32'(r_u4[31:F]);
        if (r_u4[31] || idx <= 32'd1) begin
            n_base = '0;
        end else if (idx > num32 - 32'd3) begin
            n_base = AW'(num32 - 32'd4);
        end else begin
            n_base = AW'(idx - 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_base5 <= n_base;
        r_u5    <= r_u4;
        r_clip5 <= r_clip4;
    end

    // stage 5: banked table, loads write and queries read here
    logic [31:0]        r_mem [4][BD];
    logic [31:0]        r_rd [4];
    logic [RW-1:0]      row_base;
    logic [RW-1:0]      wr_row;
    logic               wr_en;
    logic signed [XW-1:0] off;
    logic signed [XW-1:0] r_x6;
    logic [1:0]         r_bsel6;
    logic               r_clip6;

    assign row_base = RW'(r_base5 >> 2);
    assign wr_row   = RW'(r_sidx[5] >> 2);
    assign wr_en    = r_v[5] && (r_op[5] == cti_pkg::OP_LOAD)
                      && (32'(r_sidx[5]) < 32'(TABLE_DEPTH));

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [RW-1:0] rd_row;
        // banks below the base slot come from the next row
        assign rd_row = row_base + RW'(2'(b) < r_base5[1:0]);
        always_ff @(posedge i_clk) begin
            if (wr_en && r_sidx[5][1:0] == 2'(b)) begin
                r_mem[b][wr_row] <= r_sval[5];
            end
            r_rd[b] <= r_mem[b][rd_row];
        end
    end

    assign off = $signed((XW'(r_base5) + XW'(1)) << F);

    always_ff @(posedge i_clk) begin
        r_x6    <= XW'(r_u5) - off;
        r_bsel6 <= r_base5[1:0];
        r_clip6 <= r_clip5;
    end

    // stage 6: window rotate and coefficients
    logic signed [31:0]   p [4];
    logic signed [CW-1:0] n_c3;
    logic signed [CW-1:0] n_c2;
    logic signed [32:0]   n_c1;
    logic signed [XW-1:0] r_x7;
    logic signed [CW-1:0] r_c3_7;
    logic signed [CW-1:0] r_c2 [7:9];
    logic signed [32:0]   r_c1 [7:12];
    logic signed [31:0]   r_p1 [7:15];
    logic                 r_clip [7:16];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            p[j] = $signed(r_rd[2'(r_bsel6 + 2'(j))]);
        end
        n_c3 = 3 * (CW'(p[1]) - CW'(p[2])) + CW'(p[3]) - CW'(p[0]);
        n_c2 = 2 * CW'(p[0]) - 5 * CW'(p[1]) + 4 * CW'(p[2]) - CW'(p[3]);
        n_c1 = 33'(p[2]) - 33'(p[0]);
    end

    always_ff @(posedge i_clk) begin
        r_x7      <= r_x6;
        r_c3_7    <= n_c3;
        r_c2[7]   <= n_c2;
        r_c1[7]   <= n_c1;
        r_p1[7]   <= p[1];
        r_clip[7] <= r_clip6;
        for (int k = 8; k <= 9; k++) begin
            r_c2[k] <= r_c2[k-1];
        end
        for (int k = 8; k <= 12; k++) begin
            r_c1[k] <= r_c1[k-1];
        end
        for (int k = 8; k <= 15; k++) begin
            r_p1[k] <= r_p1[k-1];
        end
        for (int k = 8; k <= 16; k++) begin
            r_clip[k] <= r_clip[k-1];
        end
    end

    // x rides with every multiply
    logic signed [XW-1:0] r_x [8:13];

    always_ff @(posedge i_clk) begin
        r_x[8] <= r_x7;
        for (int k = 9; k <= 13; k++) begin
            r_x[k] <= r_x[k-1];
        end
    end

    // stages 7-9: x * c3, then s2
    logic signed [M1W-1:0] w_m1;
    logic signed [S2W-1:0] r_s2;

    cti_mul #(.AW(XW), .BW(CW)) u_mul_c3 (
        .i_clk (i_clk),
        .i_a   (r_x7),
        .i_b   (r_c3_7),
        .o_p   (w_m1)
    );

    always_ff @(posedge i_clk) begin
        r_s2 <= S2W'(w_m1 >>> F) + S2W'(r_c2[9]);
    end

    // stages 10-12: x * s2, then s1
    logic signed [M2W-1:0] w_m2;
    logic signed [S1W-1:0] r_s1;

    cti_mul #(.AW(XW), .BW(S2W)) u_mul_s2 (
        .i_clk (i_clk),
        .i_a   (r_x[10]),
        .i_b   (r_s2),
        .o_p   (w_m2)
    );

    always_ff @(posedge i_clk) begin
        r_s1 <= S1W'(w_m2 >>> F) + S1W'(r_c1[12]);
    end

    // stages 13-15: x * s1, round half up, add p1
    logic signed [M3W-1:0] w_m3;
    logic signed [M3W:0]   rnd;
    logic signed [TW-1:0]  r_t;

    cti_mul #(.AW(XW), .BW(S1W)) u_mul_s1 (
        .i_clk (i_clk),
        .i_a   (r_x[13]),
        .i_b   (r_s1),
        .o_p   (w_m3)
    );

    assign rnd = (M3W+1)'(w_m3) + $signed((M3W+1)'(1) << F);

    always_ff @(posedge i_clk) begin
        r_t <= TW'(rnd >>> (F + 1)) + TW'(r_p1[15]);
    end

    // stage 16: saturate to 32 bits
    logic               ovf;
    logic signed [31:0] n_val;
    logic               r_o_valid;
    logic signed [31:0] r_o_val;
    logic               r_o_sat;

    always_comb begin
        ovf = !((&r_t[TW-1:31]) || !(|r_t[TW-1:31]));
        if (!ovf) begin
            n_val = r_t[31:0];
        end else if (r_t[TW-1]) begin
            n_val = 32'sh80000000;
        end else begin
            n_val = 32'sh7fffffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_v[16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_val <= n_val;
        r_o_sat <= ovf || r_clip[16];
    end

    assign o_valid        = r_o_valid;
    assign o_interp_value = r_o_val;
    assign o_saturated    = r_o_sat;

endmodule

`default_nettype wire

// ===== rtl/core/cti_mul.sv =====
`default_nettype none

// two-stage signed multiplier: partial products on 32-bit slices of b, then sum
module cti_mul #(
    parameter int AW = 33,
    parameter int BW = 34
) (
    input  wire logic                 i_clk,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0]   o_p
);

    localparam int SW = cti_pkg::SLICE_W;
    localparam int NC = (BW + SW - 1) / SW;
    localparam int PW = NC * SW;
    localparam int PPW = AW + SW + 1;
    localparam int TW = AW + PW + 1;

    logic signed [PW-1:0]  b_ext;
    logic signed [PPW-1:0] r_pp [NC];
    logic signed [TW-1:0]  n_sum;
    logic signed [TW-1:0]  r_sum;

    assign b_ext = PW'(i_b);

    for (genvar k = 0; k < NC; k++) begin : g_pp
        logic signed [SW:0] slice;
        // top slice carries the sign, lower slices are unsigned
        if (k == NC - 1) begin : g_top
            assign slice = {b_ext[SW*k+SW-1], b_ext[SW*k+SW-1 -: SW]};
        end else begin : g_low
            assign slice = {1'b0, b_ext[SW*k+SW-1 -: SW]};
        end
        always_ff @(posedge i_clk) begin
            r_pp[k] <= i_a * slice;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NC; k++) begin
            n_sum = n_sum + (TW'(r_pp[k]) <<< (SW * k));
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_p = r_sum[AW+BW-1:0];

endmodule

`default_nettype wire
